// File: rtl/ssp_pkg.sv
// Shared types, codes and helpers of the session SPDU parser.
package ssp_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_DATA       = 3'd0;
  localparam logic [2:0] CFG_CONNECT    = 3'd1;
  localparam logic [2:0] CFG_ACCEPT     = 3'd2;
  localparam logic [2:0] CFG_FINISH     = 3'd3;
  localparam logic [2:0] CFG_DISCONNECT = 3'd4;
  localparam logic [2:0] CFG_ABORT      = 3'd5;

  // Reset values of the type code registers
  localparam logic [7:0] RST_DATA       = 8'd1;
  localparam logic [7:0] RST_CONNECT    = 8'd13;
  localparam logic [7:0] RST_ACCEPT     = 8'd14;
  localparam logic [7:0] RST_FINISH     = 8'd9;
  localparam logic [7:0] RST_DISCONNECT = 8'd10;
  localparam logic [7:0] RST_ABORT      = 8'd25;

  // Byte values with a fixed meaning
  localparam logic [7:0] USER_PARAM = 8'hC1;
  localparam logic [7:0] LONG_MARK  = 8'hFF;

  // Saturation value of the byte counter
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  // Status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SHORT       = 4'd1;
  localparam logic [3:0] ST_BAD_DHDR    = 4'd2;
  localparam logic [3:0] ST_DATA_EMPTY  = 4'd3;
  localparam logic [3:0] ST_LEN_MISS    = 4'd4;
  localparam logic [3:0] ST_BAD_PLEN    = 4'd5;
  localparam logic [3:0] ST_DUPLICATE   = 4'd6;
  localparam logic [3:0] ST_NO_USER     = 4'd7;
  localparam logic [3:0] ST_UNSUPPORTED = 4'd8;

  // SPDU kinds
  localparam logic [2:0] KIND_NONE       = 3'd0;
  localparam logic [2:0] KIND_DATA       = 3'd1;
  localparam logic [2:0] KIND_CONNECT    = 3'd2;
  localparam logic [2:0] KIND_ACCEPT     = 3'd3;
  localparam logic [2:0] KIND_FINISH     = 3'd4;
  localparam logic [2:0] KIND_DISCONNECT = 3'd5;
  localparam logic [2:0] KIND_ABORT      = 3'd6;

  // Type code registers
  typedef struct packed {
    logic [7:0] data_code;
    logic [7:0] connect_code;
    logic [7:0] accept_code;
    logic [7:0] finish_code;
    logic [7:0] disconnect_code;
    logic [7:0] abort_code;
  } ssp_cfg_t;

  // One result of the parser core
  typedef struct packed {
    logic       user_valid;
    logic [7:0] user_byte;
    logic [3:0] status;
    logic [2:0] kind;
  } ssp_result_t;

  // Map a type byte to its kind; data wins over connect and so on down
  function automatic logic [2:0] kind_of(input ssp_cfg_t cfg, input logic [7:0] b);
    logic [2:0] k;
    k = KIND_NONE;
    if (b == cfg.data_code) k = KIND_DATA;
    else if (b == cfg.connect_code) k = KIND_CONNECT;
    else if (b == cfg.accept_code) k = KIND_ACCEPT;
    else if (b == cfg.finish_code) k = KIND_FINISH;
    else if (b == cfg.disconnect_code) k = KIND_DISCONNECT;
    else if (b == cfg.abort_code) k = KIND_ABORT;
    return k;
  endfunction

endpackage

// File: rtl/ssp_core.sv
// Per-frame parse state and the single-pass byte update of the SPDU parser.
module ssp_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  ssp_pkg::ssp_cfg_t    cfg,
  output ssp_pkg::ssp_result_t result
);

  localparam logic [3:0] PH_TYPE       = 4'd0;
  localparam logic [3:0] PH_D1         = 4'd1;
  localparam logic [3:0] PH_D2         = 4'd2;
  localparam logic [3:0] PH_D3         = 4'd3;
  localparam logic [3:0] PH_DU         = 4'd4;
  localparam logic [3:0] PH_LEN_FIRST  = 4'd5;
  localparam logic [3:0] PH_LEN_HI     = 4'd6;
  localparam logic [3:0] PH_LEN_LO     = 4'd7;
  localparam logic [3:0] PH_PARAM_ID   = 4'd8;
  localparam logic [3:0] PH_PLEN_FIRST = 4'd9;
  localparam logic [3:0] PH_PLEN_HI    = 4'd10;
  localparam logic [3:0] PH_PLEN_LO    = 4'd11;
  localparam logic [3:0] PH_VALUE      = 4'd12;
  localparam logic [3:0] PH_DRAIN_D    = 4'd13;
  localparam logic [3:0] PH_DRAIN_P    = 4'd14;

  logic [3:0]  phase, phase_next;
  logic [7:0]  type_byte, type_byte_next;
  logic [15:0] decl_len, decl_len_next;
  logic [7:0]  len_hi, len_hi_next;
  logic [16:0] count, count_next;
  logic [15:0] value_left, value_left_next;
  logic        cur_user, cur_user_next;
  logic        user_seen, user_seen_next;
  logic [3:0]  err, err_next;

  logic        do_hdr;
  logic [15:0] hdr_len;
  logic        hdr_bad;
  logic [15:0] value_dec;
  logic [16:0] decl_ext;

  // Compute the next state and the result for the byte in flight
  always_comb begin
    phase_next      = phase;
    type_byte_next  = type_byte;
    decl_len_next   = decl_len;
    len_hi_next     = len_hi;
    count_next      = count;
    value_left_next = value_left;
    cur_user_next   = cur_user;
    user_seen_next  = user_seen;
    err_next        = err;
    do_hdr          = 1'b0;
    result          = '0;

    // Count bytes after the length field, saturating
    if (phase >= PH_PARAM_ID && phase != PH_DRAIN_D && count != ssp_pkg::COUNT_MAX) begin
      count_next = count + 17'd1;
    end

    hdr_len   = (phase == PH_PLEN_LO) ? {len_hi, in_byte} : {8'd0, in_byte};
    decl_ext  = {1'b0, decl_len};
    hdr_bad   = (count_next > decl_ext) || ({1'b0, hdr_len} > (decl_ext - count_next));
    value_dec = (value_left != 16'd0) ? value_left - 16'd1 : value_left;

    unique case (phase)
      PH_TYPE: begin
        type_byte_next = in_byte;
        phase_next = (in_byte == cfg.data_code) ? PH_D1 : PH_LEN_FIRST;
      end
      PH_D1, PH_D3: begin
        if (in_byte != 8'd0) begin
          err_next   = ssp_pkg::ST_BAD_DHDR;
          phase_next = PH_DRAIN_D;
        end else begin
          phase_next = phase + 4'd1;
        end
      end
      PH_D2: begin
        if (in_byte != 8'd1) begin
          err_next   = ssp_pkg::ST_BAD_DHDR;
          phase_next = PH_DRAIN_D;
        end else begin
          phase_next = PH_D3;
        end
      end
      PH_DU: begin
        result.user_valid = 1'b1;
        result.user_byte  = in_byte;
      end
      PH_LEN_FIRST: begin
        if (in_byte == ssp_pkg::LONG_MARK) begin
          phase_next = PH_LEN_HI;
        end else begin
          decl_len_next = {8'd0, in_byte};
          phase_next    = PH_PARAM_ID;
        end
      end
      PH_LEN_HI, PH_PLEN_HI: begin
        len_hi_next = in_byte;
        phase_next  = phase + 4'd1;
      end
      PH_LEN_LO: begin
        decl_len_next = {len_hi, in_byte};
        phase_next    = PH_PARAM_ID;
      end
      PH_PARAM_ID: begin
        cur_user_next = (in_byte == ssp_pkg::USER_PARAM);
        phase_next    = PH_PLEN_FIRST;
      end
      PH_PLEN_FIRST: begin
        if (in_byte == ssp_pkg::LONG_MARK) phase_next = PH_PLEN_HI;
        else do_hdr = 1'b1;
      end
      PH_PLEN_LO: begin
        do_hdr = 1'b1;
      end
      PH_VALUE: begin
        if (cur_user && err == ssp_pkg::ST_OK) begin
          result.user_valid = 1'b1;
          result.user_byte  = in_byte;
        end
        value_left_next = value_dec;
        if (value_dec == 16'd0) phase_next = PH_PARAM_ID;
      end
      default: begin
      end
    endcase

    // Close a parameter header: check its length and the user data rule
    if (do_hdr) begin
      if (hdr_bad) begin
        err_next   = ssp_pkg::ST_BAD_PLEN;
        phase_next = PH_DRAIN_P;
      end else if (cur_user && user_seen) begin
        err_next   = ssp_pkg::ST_DUPLICATE;
        phase_next = PH_DRAIN_P;
      end else begin
        if (cur_user && hdr_len != 16'd0) user_seen_next = 1'b1;
        value_left_next = hdr_len;
        phase_next = (hdr_len != 16'd0) ? PH_VALUE : PH_PARAM_ID;
      end
    end

    // Report the frame status on the last byte
    if (in_last) begin
      result.kind = ssp_pkg::kind_of(cfg, type_byte_next);
      if (phase == PH_TYPE) begin
        result.status = ssp_pkg::ST_SHORT;
      end else if (phase_next <= PH_DU || phase_next == PH_DRAIN_D) begin
        if (err_next != ssp_pkg::ST_OK) result.status = err_next;
        else if (phase_next == PH_D2 || phase_next == PH_D3) result.status = ssp_pkg::ST_BAD_DHDR;
        else if (phase == PH_D3) result.status = ssp_pkg::ST_DATA_EMPTY;
        else result.status = ssp_pkg::ST_OK;
      end else if (phase_next == PH_LEN_HI || phase_next == PH_LEN_LO) begin
        result.status = ssp_pkg::ST_LEN_MISS;
      end else if (count_next != {1'b0, decl_len_next}) begin
        result.status = ssp_pkg::ST_LEN_MISS;
      end else if (err_next != ssp_pkg::ST_OK) begin
        result.status = err_next;
      end else if (phase_next >= PH_PLEN_FIRST && phase_next <= PH_PLEN_LO) begin
        result.status = ssp_pkg::ST_BAD_PLEN;
      end else if (result.kind == ssp_pkg::KIND_NONE || result.kind == ssp_pkg::KIND_DATA) begin
        result.status = ssp_pkg::ST_UNSUPPORTED;
      end else if (result.kind != ssp_pkg::KIND_ABORT && !user_seen_next) begin
        result.status = ssp_pkg::ST_NO_USER;
      end else begin
        result.status = ssp_pkg::ST_OK;
      end
    end
  end

  // Hold state between bytes; drop it at frame end
  always_ff @(posedge clk) begin
    if (rst || (fire && in_last)) begin
      phase      <= PH_TYPE;
      type_byte  <= '0;
      decl_len   <= '0;
      len_hi     <= '0;
      count      <= '0;
      value_left <= '0;
      cur_user   <= 1'b0;
      user_seen  <= 1'b0;
      err        <= ssp_pkg::ST_OK;
    end else if (fire) begin
      phase      <= phase_next;
      type_byte  <= type_byte_next;
      decl_len   <= decl_len_next;
      len_hi     <= len_hi_next;
      count      <= count_next;
      value_left <= value_left_next;
      cur_user   <= cur_user_next;
      user_seen  <= user_seen_next;
      err        <= err_next;
    end
  end

endmodule

// File: rtl/session_spdu_parser_top.sv
// Session SPDU parser: input register, parser core, result register, config registers.
//
// Usage:
//   Bytes of one SPDU enter on the s_t* channel, one per transaction, with
//   s_tlast on the final byte. Every byte yields one result transaction on
//   m_t*: m_tuser[0] flags a user data byte carried in m_tdata[7:0]; on the
//   result with m_tlast set, m_tdata[11:8] holds the frame status and
//   m_tuser[3:1] the SPDU kind. On a nonzero status the consumer drops the
//   user bytes of that frame.
//   Type codes are written through cfg_valid/cfg_index/cfg_data while the
//   block is idle; cfg_ready is always high and unknown indexes are ignored.
// Timing:
//   A byte accepted into the input register is parsed by the core there and
//   shows on m_t* once the result register has taken it. One byte per cycle
//   is sustained while m_tready stays high; the parser core updates all of
//   its state in a single pass per byte.
// Reset and stall:
//   rst clears both valid stages, the parse state and restores the default
//   type codes. When m_tready is low the result holds; an empty input register
//   still takes one more byte, then s_tready drops until the result drains.
module session_spdu_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] user_byte, [11:8] status, [15:12] zero
  output logic        m_tlast,   // frame_end
  output logic [3:0]  m_tuser,   // [0] user_valid, [3:1] spdu_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  ssp_pkg::ssp_cfg_t    cfg;
  ssp_pkg::ssp_result_t result;

  logic       in_vld;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_free;
  logic       advance;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign advance   = in_vld && out_free;
  assign s_tready  = !in_vld || out_free;

  // Write type code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_code       <= ssp_pkg::RST_DATA;
      cfg.connect_code    <= ssp_pkg::RST_CONNECT;
      cfg.accept_code     <= ssp_pkg::RST_ACCEPT;
      cfg.finish_code     <= ssp_pkg::RST_FINISH;
      cfg.disconnect_code <= ssp_pkg::RST_DISCONNECT;
      cfg.abort_code      <= ssp_pkg::RST_ABORT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ssp_pkg::CFG_DATA:       cfg.data_code       <= cfg_data;
        ssp_pkg::CFG_CONNECT:    cfg.connect_code    <= cfg_data;
        ssp_pkg::CFG_ACCEPT:     cfg.accept_code     <= cfg_data;
        ssp_pkg::CFG_FINISH:     cfg.finish_code     <= cfg_data;
        ssp_pkg::CFG_DISCONNECT: cfg.disconnect_code <= cfg_data;
        ssp_pkg::CFG_ABORT:      cfg.abort_code      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Capture an input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte_q <= s_tdata;
      in_last_q <= s_tlast;
    end
  end

  ssp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .in_byte (in_byte_q),
    .in_last (in_last_q),
    .cfg     (cfg),
    .result  (result)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'd0, result.status, result.user_byte};
      m_tlast <= in_last_q;
      m_tuser <= {result.kind, result.user_valid};
    end
  end

endmodule

// File: rtl/ssp_checker.sv
// Port-level checks of the session SPDU parser, bound to the top level.
module ssp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast,
  input logic [3:0]  m_tuser
);

  // Non-user results carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
    else $error("user byte nonzero without user flag");

  // Status and kind only on the frame end result
  a_mid_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[11:8] == ssp_pkg::ST_OK && m_tuser[3:1] == 3'd0)
    else $error("status or kind set before frame end");

  // Codes stay within their ranges
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[11:8] <= ssp_pkg::ST_UNSUPPORTED &&
                 m_tuser[3:1] <= ssp_pkg::KIND_ABORT && m_tdata[15:12] == 4'd0)
    else $error("status or kind out of range");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind session_spdu_parser_top ssp_checker u_ssp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
